// ===== design/qsrm_pkg.sv =====
// Shared widths, result codes and types of the query slot ring manager.
`timescale 1ns / 1ps

package qsrm_pkg;

  // Ring geometry.
  localparam int SLOTS  = 256;
  localparam int PTR_W  = $clog2(SLOTS);
  localparam int SLOT_W = 8;
  localparam int REM_W  = 16;
  localparam int PAY_W  = 64;

  // Result kind codes.
  localparam logic [1:0] KIND_FWD  = 2'd0;
  localparam logic [1:0] KIND_NEW  = 2'd1;
  localparam logic [1:0] KIND_HALT = 2'd2;

  // One input request as seen by the datapath.
  typedef struct packed {
    logic              old_valid;
    logic [REM_W-1:0]  old_remain;
    logic [SLOT_W-1:0] old_slot;
    logic              old_tail;
    logic              old_end;
    logic [PAY_W-1:0]  old_payload;
    logic [1:0]        new_count;
    logic [PAY_W-1:0]  first_new_payload;
    logic              first_new_end;
    logic [PAY_W-1:0]  second_new_payload;
    logic              second_new_end;
  } in_item_t;

  // One result, without its position marker.
  typedef struct packed {
    logic [1:0]        kind;
    logic [REM_W-1:0]  remain;
    logic [SLOT_W-1:0] slot;
    logic              tail;
    logic [PAY_W-1:0]  payload;
    logic              end_mark;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sel_first;
  } ctl_cmd_t;

  // Status from the datapath, valid in the cycle of a request.
  typedef struct packed {
    logic halt;
    logic two;
    logic none;
  } dp_stat_t;

endpackage

// ===== design/qsrm_ctrl.sv =====
// Controller state machine: accepts requests and sequences the result strobes.
`timescale 1ns / 1ps

module qsrm_ctrl import qsrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     out_valid,
  output logic     out_last_of_run
);

  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_EMIT_FIRST = 5'b00010,
    ST_EMIT_LAST  = 5'b00100,
    ST_EMIT_HALT  = 5'b01000,
    ST_HALTED     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Requests are taken only when idle; once halted they are ignored.
  assign busy = (state_r == ST_EMIT_FIRST) || (state_r == ST_EMIT_LAST) ||
                (state_r == ST_EMIT_HALT);
  assign cmd.accept    = start && (state_r == ST_IDLE);
  assign cmd.sel_first = (state_r == ST_EMIT_FIRST);
  assign out_valid       = busy;
  assign out_last_of_run = (state_r == ST_EMIT_LAST) || (state_r == ST_EMIT_HALT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (stat.halt)      state_nxt = ST_EMIT_HALT;
          else if (stat.two)  state_nxt = ST_EMIT_FIRST;
          else if (!stat.none) state_nxt = ST_EMIT_LAST;
        end
      end
      ST_EMIT_FIRST: state_nxt = ST_EMIT_LAST;
      ST_EMIT_LAST:  state_nxt = ST_IDLE;
      ST_EMIT_HALT:  state_nxt = ST_HALTED;
      ST_HALTED:     state_nxt = ST_HALTED;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A first result is always followed by the last one.
  a_first_then_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_FIRST |=> state_r == ST_EMIT_LAST)
    else $error("first result not followed by last result");

  // Halting is permanent until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HALTED |=> state_r == ST_HALTED && !out_valid)
    else $error("block left the halted state");

  // No request is taken while results are being delivered.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !out_valid)
    else $error("request accepted during result delivery");

endmodule

// ===== design/qsrm_datapath.sv =====
// Datapath: slot busy bits, insert pointer and the two result registers.
`timescale 1ns / 1ps

module qsrm_datapath import qsrm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  output result_t  res
);

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(SLOTS);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(SLOTS - 1);

  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  result_t          first_r, first_nxt;
  result_t          last_r, last_nxt;

  logic             have0, have1;
  logic             fin, halt, handover, free_slot, fwd, ins, busy_eff;
  logic [PTR_W-1:0] old_idx;
  result_t          old_res, ins_res, halt_res;

  // Decode the returning query and the offers.
  always_comb begin
    have0     = (item.new_count != 2'd0);
    have1     = item.new_count[1];
    old_idx   = item.old_slot[PTR_W-1:0];
    fin       = item.old_valid && (item.old_remain == '0);
    halt      = fin && item.old_end;
    handover  = fin && !item.old_end && have0;
    free_slot = fin && !item.old_end && !have0 &&
                ({1'b0, item.old_slot} < SLOT_LIMIT);
    fwd       = item.old_valid && (item.old_remain != '0);
    // A slot freed in this request is free for insertion too.
    busy_eff  = busy_r[ptr_r] && !(free_slot && (old_idx == ptr_r));
    ins       = !halt && !busy_eff && (handover ? have1 : have0);
  end

  // Candidate results.
  always_comb begin
    if (handover) begin
      old_res.kind     = KIND_NEW;
      old_res.remain   = '0;
      old_res.slot     = item.old_slot;
      old_res.tail     = item.first_new_end;
      old_res.payload  = item.first_new_payload;
      old_res.end_mark = 1'b0;
    end else begin
      old_res.kind     = KIND_FWD;
      old_res.remain   = item.old_remain;
      old_res.slot     = item.old_slot;
      old_res.tail     = item.old_tail;
      old_res.payload  = item.old_payload;
      old_res.end_mark = (item.old_remain == REM_W'(1)) && item.old_tail;
    end
    ins_res.kind     = KIND_NEW;
    ins_res.remain   = '0;
    ins_res.slot     = SLOT_W'(ptr_r);
    ins_res.tail     = handover ? item.second_new_end : item.first_new_end;
    ins_res.payload  = handover ? item.second_new_payload : item.first_new_payload;
    ins_res.end_mark = 1'b0;
    halt_res         = '0;
    halt_res.kind    = KIND_HALT;
  end

  // Status for the controller.
  assign stat.halt = halt;
  assign stat.two  = (fwd || handover) && ins;
  assign stat.none = !(fwd || handover) && !ins;

  // Result placement and ring state update.
  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    busy_nxt  = busy_r;
    ptr_nxt   = ptr_r;
    if (cmd.accept) begin
      if (halt) begin
        last_nxt = halt_res;
      end else begin
        first_nxt = old_res;
        last_nxt  = ins ? ins_res : old_res;
        if (free_slot) busy_nxt[old_idx] = 1'b0;
        if (ins) begin
          busy_nxt[ptr_r] = 1'b1;
          ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        end
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      ptr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  assign res = cmd.sel_first ? first_r : last_r;

  // The pointer only moves on a request that inserts.
  a_ptr_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.accept |=> $stable(ptr_r) && $stable(busy_r))
    else $error("ring state changed without a request");

  // An insertion leaves its slot marked busy.
  a_ins_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && ins |=> busy_r[$past(ptr_r)])
    else $error("inserted slot not marked busy");

endmodule

// ===== design/query_slot_ring_manager_unit.sv =====
// Top level of the query slot ring manager: controller plus datapath.
// The first result is strobed in the cycle after the request is taken.
// A request yields zero to two results, which the controller delivers from the two
// result registers one per cycle; no new request is taken until the last is out.
// The receiver cannot stall; each result is on the ports for one cycle only.
// Reset (synchronous, rst_n low) frees every slot, zeroes the pointer, clears halt.
`timescale 1ns / 1ps

module query_slot_ring_manager_unit import qsrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_old_valid,
  input  logic [REM_W-1:0]  in_old_remain,
  input  logic [SLOT_W-1:0] in_old_slot,
  input  logic              in_old_tail,
  input  logic              in_old_end,
  input  logic [PAY_W-1:0]  in_old_payload,
  input  logic [1:0]        in_new_count,
  input  logic [PAY_W-1:0]  in_first_new_payload,
  input  logic              in_first_new_end,
  input  logic [PAY_W-1:0]  in_second_new_payload,
  input  logic              in_second_new_end,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [REM_W-1:0]  out_remain,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_tail,
  output logic [PAY_W-1:0]  out_payload,
  output logic              out_end,
  output logic              out_last_of_run
);

  in_item_t item;
  ctl_cmd_t cmd;
  dp_stat_t stat;
  result_t  res;

  // Gather the request fields.
  always_comb begin
    item.old_valid          = in_old_valid;
    item.old_remain         = in_old_remain;
    item.old_slot           = in_old_slot;
    item.old_tail           = in_old_tail;
    item.old_end            = in_old_end;
    item.old_payload        = in_old_payload;
    item.new_count          = in_new_count;
    item.first_new_payload  = in_first_new_payload;
    item.first_new_end      = in_first_new_end;
    item.second_new_payload = in_second_new_payload;
    item.second_new_end     = in_second_new_end;
  end

  qsrm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .stat            (stat),
    .cmd             (cmd),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_last_of_run (out_last_of_run)
  );

  qsrm_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat),
    .res   (res)
  );

  // Result fields.
  assign out_kind    = res.kind;
  assign out_remain  = res.remain;
  assign out_slot    = res.slot;
  assign out_tail    = res.tail;
  assign out_payload = res.payload;
  assign out_end     = res.end_mark;

endmodule
